// File: rtl/core/tsc_pkg.sv
// Shared types and constants for the timestamp clip selector.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int TIME_BITS   = 48;
    localparam int TAG_BITS    = 16;
    localparam int POS_BITS    = 5;
    localparam int STAT_BITS   = 2;
    localparam int CFG_DATA_BITS = 20;
    // Targets and gaps: a timestamp plus the widest clip offset, with a sign bit.
    localparam int TW          = TIME_BITS + 27;
    localparam logic [63:0] GAP_START = 64'd10000000000;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_HISTORY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_CLIP_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_FRAME_STRIDE  = 2'd2;
    localparam logic [1:0] CFG_MATCH_MARGIN  = 2'd3;

    localparam logic [STAT_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STAT_BITS-1:0] STATUS_UNMATCHED = 2'd2;

    typedef enum logic
    {
        CMD_PUSH  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        logic                 req_type;
        logic [TIME_BITS-1:0] timestamp;
        logic [TAG_BITS-1:0]  payload_tag;
    } req_t;

    typedef struct packed
    {
        logic [TAG_BITS-1:0]  payload_tag_res;
        logic [POS_BITS-1:0]  clip_position;
        logic [STAT_BITS-1:0] status;
        logic                 last;
    } res_t;

    typedef struct packed
    {
        cmd_kind_t            kind;
        logic [TIME_BITS-1:0] ts;
        logic [TAG_BITS-1:0]  tag;
    } cmd_t;

    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed
    {
        logic [5:0]  history_limit;
        logic [5:0]  clip_length;
        logic [19:0] frame_stride;
        logic [19:0] match_margin;
    } cfg_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN_ADDR,
        ST_SCAN_CMP,
        ST_EMIT_ADDR,
        ST_EMIT_TAG,
        ST_EMIT_OUT,
        ST_FAIL
    } state_t;

endpackage

// File: rtl/core/tsc_front.sv
// Front end: takes request words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module tsc_front
    import tsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    req,
    output logic    busy,
    output q_head_t head,
    input  logic    pop
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             push_en;
    logic             pop_en;
    cmd_t             cmd_in;

    assign busy    = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign push_en = start && !busy;
    assign pop_en  = pop && (count_reg != '0);

    always_comb
    begin
        cmd_in.kind = req.req_type ? CMD_QUERY : CMD_PUSH;
        cmd_in.ts   = req.timestamp;
        cmd_in.tag  = req.payload_tag;
    end

    always_comb
    begin
        wr_ptr_next = push_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != '0);
        head.cmd   = q_mem[rd_ptr_reg];
    end

endmodule

// File: rtl/core/tsc_back.sv
// Back end: frame history, per-slot nearest-frame scan and result emission.
`timescale 1ns / 1ps

module tsc_back
    import tsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_CLIP      = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  q_head_t head,
    output logic    pop,
    output res_t    res,
    output logic    res_strobe
);

    localparam int PW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int NW = $clog2(MAX_CLIP + 1);
    localparam int SW = (MAX_CLIP > 1) ? $clog2(MAX_CLIP) : 1;
    localparam logic [CW-1:0] LIM_MAX = CW'(HISTORY_DEPTH - 1);

    state_t state_reg, state_next;

    logic [PW-1:0]          oldest_reg, oldest_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   res_strobe_reg, res_strobe_next;

    logic [NW-1:0]          n_reg, n_next;
    logic [NW-1:0]          k_reg, k_next;
    logic [PW-1:0]          idx_reg, idx_next;
    logic signed [TW-1:0]   target_reg, target_next;
    logic [TW-1:0]          best_reg, best_next;
    logic                   found_reg, found_next;
    logic [PW-1:0]          choice_reg, choice_next;
    logic [TIME_BITS-1:0]   ts_reg, ts_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [STAT_BITS-1:0]   fail_reg, fail_next;
    res_t                   res_reg, res_next;

    logic [TIME_BITS-1:0]   time_mem [HISTORY_DEPTH];
    logic [TAG_BITS-1:0]    tag_mem  [HISTORY_DEPTH];
    logic [PW-1:0]          slot_mem [MAX_CLIP];
    logic [TIME_BITS-1:0]   time_rd_reg;
    logic [TAG_BITS-1:0]    tag_rd_reg;
    logic [PW-1:0]          slot_rd_reg;

    logic [PW-1:0]          time_rd_addr;
    logic [PW-1:0]          tag_rd_addr;
    logic [PW-1:0]          wr_addr;
    logic [SW-1:0]          slot_wr_addr;
    logic                   push_we;
    logic                   slot_we;

    logic [CW-1:0]          lim;
    logic [NW-1:0]          n_sat;
    logic signed [TW-1:0]   diff;
    logic [TW-1:0]          gap;
    logic                   hit;
    logic                   margin_hit;
    logic                   found_now;
    logic [PW-1:0]          choice_now;
    logic                   scan_more;
    logic                   slot_last;

    // Logical history index to physical ring address; both terms stay below
    // twice the depth, so one conditional subtract wraps it.
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [CW-1:0] logical);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(logical);
        if (sum >= (CW+1)'(HISTORY_DEPTH))
        begin
            sum = sum - (CW+1)'(HISTORY_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    always_comb
    begin
        if (int'(cfg.history_limit) > HISTORY_DEPTH - 1)
        begin
            lim = LIM_MAX;
        end
        else
        begin
            lim = CW'(cfg.history_limit);
        end
        if (cfg.clip_length == '0)
        begin
            n_sat = NW'(1);
        end
        else if (int'(cfg.clip_length) > MAX_CLIP)
        begin
            n_sat = NW'(MAX_CLIP);
        end
        else
        begin
            n_sat = NW'(cfg.clip_length);
        end
    end

    // Exact distance between the stored time and a possibly negative target.
    assign diff       = $signed(TW'(time_rd_reg)) - target_reg;
    assign gap        = diff[TW-1] ? $unsigned(-diff) : $unsigned(diff);
    assign hit        = (gap < best_reg);
    assign margin_hit = (gap < TW'(cfg.match_margin));
    assign found_now  = found_reg || (hit && margin_hit);
    assign choice_now = (hit && margin_hit) ? idx_reg : choice_reg;
    assign scan_more  = hit && (idx_reg != '0);
    assign slot_last  = (k_reg == n_reg - NW'(1));

    assign time_rd_addr = phys(oldest_reg, CW'(idx_reg));
    assign tag_rd_addr  = phys(oldest_reg, CW'(slot_rd_reg));
    assign wr_addr      = phys(oldest_reg, count_reg);
    assign slot_wr_addr = SW'(n_reg - NW'(1) - k_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.cmd.kind == CMD_PUSH)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_FAIL;
                    end
                    else
                    begin
                        state_next = ST_SCAN_ADDR;
                    end
                end
            end
            ST_PUSH:      state_next = ST_IDLE;
            ST_SCAN_ADDR: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (scan_more)
                begin
                    state_next = ST_SCAN_ADDR;
                end
                else if (!found_now)
                begin
                    state_next = ST_FAIL;
                end
                else if (slot_last)
                begin
                    state_next = ST_EMIT_ADDR;
                end
                else
                begin
                    state_next = ST_SCAN_ADDR;
                end
            end
            ST_EMIT_ADDR: state_next = ST_EMIT_TAG;
            ST_EMIT_TAG:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:  state_next = slot_last ? ST_IDLE : ST_EMIT_ADDR;
            ST_FAIL:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs and memory strobes.
    always_comb
    begin
        pop             = 1'b0;
        push_we         = 1'b0;
        slot_we         = 1'b0;
        res_strobe_next = 1'b0;
        res_next        = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pop = head.valid;
            end
            ST_PUSH:
            begin
                push_we = 1'b1;
            end
            ST_SCAN_CMP:
            begin
                slot_we = !scan_more;
            end
            ST_EMIT_OUT:
            begin
                res_strobe_next          = 1'b1;
                res_next.payload_tag_res = tag_rd_reg;
                res_next.clip_position   = POS_BITS'(k_reg);
                res_next.status          = STATUS_OK;
                res_next.last            = slot_last;
            end
            ST_FAIL:
            begin
                res_strobe_next          = 1'b1;
                res_next.payload_tag_res = '0;
                res_next.clip_position   = '0;
                res_next.status          = fail_reg;
                res_next.last            = 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        target_next = target_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        choice_next = choice_reg;
        ts_next     = ts_reg;
        tag_next    = tag_reg;
        fail_next   = fail_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    ts_next  = head.cmd.ts;
                    tag_next = head.cmd.tag;
                    if (head.cmd.kind == CMD_PUSH)
                    begin
                        // A lowered limit drops all surplus entries at once.
                        if (count_reg > lim)
                        begin
                            oldest_next = phys(oldest_reg, count_reg - lim);
                            count_next  = lim;
                        end
                    end
                    else
                    begin
                        fail_next   = STATUS_EMPTY;
                        n_next      = n_sat;
                        k_next      = '0;
                        idx_next    = PW'(count_reg - CW'(1));
                        target_next = $signed(TW'(head.cmd.ts));
                        best_next   = TW'(GAP_START);
                        found_next  = 1'b0;
                    end
                end
            end
            ST_PUSH:
            begin
                count_next = count_reg + CW'(1);
            end
            ST_SCAN_CMP:
            begin
                if (hit)
                begin
                    best_next = gap;
                end
                found_next  = found_now;
                choice_next = choice_now;
                if (scan_more)
                begin
                    idx_next = idx_reg - PW'(1);
                end
                else if (!found_now)
                begin
                    fail_next = STATUS_UNMATCHED;
                end
                else if (slot_last)
                begin
                    k_next = '0;
                end
                else
                begin
                    k_next      = k_reg + NW'(1);
                    idx_next    = PW'(count_reg - CW'(1));
                    target_next = target_reg - $signed(TW'(cfg.frame_stride));
                    best_next   = TW'(GAP_START);
                    found_next  = 1'b0;
                end
            end
            ST_EMIT_OUT:
            begin
                k_next = k_reg + NW'(1);
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            oldest_reg     <= '0;
            count_reg      <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        target_reg <= target_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        choice_reg <= choice_next;
        ts_reg     <= ts_next;
        tag_reg    <= tag_next;
        fail_reg   <= fail_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            time_mem[wr_addr] <= ts_reg;
            tag_mem[wr_addr]  <= tag_reg;
        end
        time_rd_reg <= time_mem[time_rd_addr];
        tag_rd_reg  <= tag_mem[tag_rd_addr];
    end

    // Slots are filled newest target first and read back oldest target first.
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wr_addr] <= choice_now;
        end
        slot_rd_reg <= slot_mem[SW'(k_reg)];
    end

    assign res        = res_reg;
    assign res_strobe = res_strobe_reg;

endmodule

// File: rtl/core/timestamp_clip_selector.sv
// Top level of the timestamp clip selector: configuration registers, front and back ends.
// Push: popped in ST_IDLE, then written to the history in ST_PUSH; no result.
// Query: each history entry visited per clip slot, newest first, takes ST_SCAN_ADDR and
// ST_SCAN_CMP (single registered time-store read port); each word ST_EMIT_ADDR/TAG/OUT.
// Empty history or an unmatched slot gives one word, through ST_FAIL, after the scan stops.
// Reset empties the history and queue and loads register defaults; results never stall.
`timescale 1ns / 1ps

module timestamp_clip_selector
    import tsc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64,
    parameter int MAX_CLIP      = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  req_t                     req,
    output res_t                     res,
    output logic                     res_strobe,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    q_head_t head;
    logic    pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HISTORY_LIMIT: cfg_next.history_limit = cfg_data[5:0];
                CFG_CLIP_LENGTH:   cfg_next.clip_length   = cfg_data[5:0];
                CFG_FRAME_STRIDE:  cfg_next.frame_stride  = cfg_data;
                CFG_MATCH_MARGIN:  cfg_next.match_margin  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.history_limit <= 6'd31;
            cfg_reg.clip_length   <= 6'd16;
            cfg_reg.frame_stride  <= 20'd33;
            cfg_reg.match_margin  <= 20'd16;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsc_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    tsc_back
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_CLIP      (MAX_CLIP)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .pop        (pop),
        .res        (res),
        .res_strobe (res_strobe)
    );

endmodule

// File: rtl/core/tsc_checker.sv
// Port-level checks for the timestamp clip selector and their binding.
`timescale 1ns / 1ps

module tsc_checker
    import tsc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input res_t res,
    input logic res_strobe
);

    // A failure word always ends its query.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && (res.status != STATUS_OK) |-> res.last)
    else $error("failure word without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && (res.status != STATUS_OK)
        |-> (res.payload_tag_res == '0) && (res.clip_position == '0))
    else $error("failure word carries tag or position");

    // Result words are never strobed back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |=> !res_strobe)
    else $error("result words in consecutive cycles");

    // The queue only fills on an accepted word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

endmodule

bind timestamp_clip_selector tsc_checker u_tsc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .res        (res),
    .res_strobe (res_strobe)
);
